// ===== hw/rtl/mads_pkg.sv =====
// shared constants, codes and types of the dram read/write scheduler
`timescale 1ns / 1ps
package mads_pkg;

    // queue and thread geometry
    localparam int READ_DEPTH   = 64;
    localparam int WRITE_DEPTH  = 64;
    localparam int THREAD_COUNT = 16;
    localparam int ROW_BITS     = 16;

    localparam int MAX_DEPTH = (READ_DEPTH > WRITE_DEPTH) ? READ_DEPTH : WRITE_DEPTH;
    localparam int RIDX_W    = $clog2(READ_DEPTH);
    localparam int WIDX_W    = $clog2(WRITE_DEPTH);
    localparam int SIDX_W    = $clog2(MAX_DEPTH);
    localparam int SCN_W     = $clog2(MAX_DEPTH + 1);
    localparam int RCNT_W    = $clog2(READ_DEPTH + 1);
    localparam int WCNT_W    = $clog2(WRITE_DEPTH + 1);
    localparam int THR_W     = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
    localparam int ROW_W     = (ROW_BITS < 16) ? ROW_BITS : 16;

    // field and datapath widths
    localparam int SLOT_W    = 6;
    localparam int STAMP_W   = 16;
    localparam int TIME_W    = 48;
    localparam int PRIO_W    = TIME_W + 1;
    localparam int APER_W    = 16;
    localparam int WM_W      = 7;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_CNT_W = $clog2(TIME_W);

    // command queue between front and back
    localparam int QDEPTH  = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // configuration reset values and indexes
    localparam logic [WM_W-1:0]   HI_WM_RST = 7'd40;
    localparam logic [WM_W-1:0]   LO_WM_RST = 7'd20;
    localparam logic [APER_W-1:0] AGING_RST = 16'd40;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_WM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AGING   = 2'd2;

    // request type codes
    localparam logic [2:0] REQ_ADD_RD = 3'd0;
    localparam logic [2:0] REQ_ADD_WR = 3'd1;
    localparam logic [2:0] REQ_FLAGS  = 3'd2;
    localparam logic [2:0] REQ_REMOVE = 3'd3;
    localparam logic [2:0] REQ_SCHED  = 3'd4;

    // decoded operation codes
    localparam logic [2:0] OP_ADD_RD = 3'd0;
    localparam logic [2:0] OP_ADD_WR = 3'd1;
    localparam logic [2:0] OP_FLAGS  = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_SCHED  = 3'd4;
    localparam logic [2:0] OP_BAD    = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic        queue_select;
        logic [5:0]  slot_index;
        logic [3:0]  thread_num;
        logic [1:0]  rank_num;
        logic [2:0]  bank_num;
        logic [15:0] row_num;
        logic        ready_flag;
        logic        pending_flag;
        logic [47:0] now_cycle;
    } mads_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] assigned_slot;
        logic       issued;
        logic       issued_queue;
        logic [5:0] issued_slot;
        logic       drain_mode;
    } mads_rsp_t;

    typedef struct packed {
        logic [2:0]        op;
        logic              qsel;
        logic [SLOT_W-1:0] slot;
        logic [THR_W-1:0]  thread;
        logic [1:0]        rank;
        logic [2:0]        bank;
        logic [ROW_W-1:0]  row;
        logic              rdy;
        logic              pend;
        logic [TIME_W-1:0] now;
    } mads_cmd_t;

    typedef struct packed {
        logic [WM_W-1:0]   high_wm;
        logic [WM_W-1:0]   low_wm;
        logic [APER_W-1:0] aging;
    } mads_cfg_t;

    // read queue entry as stored in memory
    typedef struct packed {
        logic [THR_W-1:0]   thread;
        logic [1:0]         rank;
        logic [2:0]         bank;
        logic [ROW_W-1:0]   row;
        logic [STAMP_W-1:0] stamp;
    } mads_rent_t;

endpackage

// ===== hw/rtl/mads_req_if.sv =====
// request channel interface
`timescale 1ns / 1ps
interface mads_req_if;
    import mads_pkg::*;
    logic      valid;
    logic      ready;
    mads_req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mads_rsp_if.sv =====
// result channel interface
`timescale 1ns / 1ps
interface mads_rsp_if;
    import mads_pkg::*;
    logic      valid;
    logic      ready;
    mads_rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mads_ram.sv =====
// generic single write port memory with registered read
`timescale 1ns / 1ps
module mads_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/mads_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module mads_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mads_pkg::TIME_W-1:0] dividend,
    input  logic [mads_pkg::APER_W-1:0] divisor,
    output logic                        done,
    output logic [mads_pkg::TIME_W-1:0] quotient
);
    import mads_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [APER_W-1:0]    rem_reg;
    logic [TIME_W-1:0]    quo_reg;
    logic [APER_W:0]      trial;
    logic [APER_W:0]      diff;
    logic                 fits;

    // trial subtract of the next partial remainder
    assign trial = {rem_reg, quo_reg[TIME_W-1]};
    assign fits  = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(TIME_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[APER_W-1:0] : trial[APER_W-1:0];
            quo_reg <= {quo_reg[TIME_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== hw/rtl/mads_front.sv =====
// front end: accepts requests, decodes them and queues commands
`timescale 1ns / 1ps
module mads_front (
    input  logic                clk,
    input  logic                rst_n,
    mads_req_if.sink            req,
    output mads_pkg::mads_cmd_t cmd,
    output logic                cmd_valid,
    input  logic                cmd_ready
);
    import mads_pkg::*;

    mads_cmd_t          q_reg [QDEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;
    mads_cmd_t          dec;
    logic               push;
    logic               pop;

    // decode the request into a command
    always_comb
    begin
        dec        = '0;
        dec.qsel   = req.data.queue_select;
        dec.slot   = req.data.slot_index;
        dec.thread = THR_W'(32'(req.data.thread_num) % THREAD_COUNT);
        dec.rank   = req.data.rank_num;
        dec.bank   = req.data.bank_num;
        dec.row    = req.data.row_num[ROW_W-1:0];
        dec.rdy    = req.data.ready_flag;
        dec.pend   = req.data.pending_flag;
        dec.now    = req.data.now_cycle;
        unique case (req.data.req_type)
            REQ_ADD_RD: dec.op = OP_ADD_RD;
            REQ_ADD_WR: dec.op = OP_ADD_WR;
            REQ_FLAGS:  dec.op = OP_FLAGS;
            REQ_REMOVE: dec.op = OP_REMOVE;
            REQ_SCHED:  dec.op = OP_SCHED;
            default:    dec.op = OP_BAD;
        endcase
    end

    assign req.ready = cnt_reg != Q_CNT_W'(QDEPTH);
    assign push      = req.valid && req.ready;
    assign cmd_valid = cnt_reg != '0;
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    // queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end
endmodule

// ===== hw/rtl/mads_back.sv =====
// back end: queue state, scans, priority aging and result register
`timescale 1ns / 1ps
module mads_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mads_pkg::mads_cmd_t cmd,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  mads_pkg::mads_cfg_t cfg,
    mads_rsp_if.source          rsp
);
    import mads_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_SCAN_W   = 3'd2;
    localparam logic [2:0] S_SCAN_HIT = 3'd3;
    localparam logic [2:0] S_DIV      = 3'd4;
    localparam logic [2:0] S_SCAN_PRI = 3'd5;
    localparam logic [2:0] S_OUT      = 3'd6;

    logic [2:0]              state_reg;
    mads_cmd_t               cmd_reg;
    logic [READ_DEPTH-1:0]   rvalid_reg;
    logic [READ_DEPTH-1:0]   rready_reg;
    logic [READ_DEPTH-1:0]   rpend_reg;
    logic [WRITE_DEPTH-1:0]  wvalid_reg;
    logic [WRITE_DEPTH-1:0]  wready_reg;
    logic [RCNT_W-1:0]       rcnt_reg;
    logic [WCNT_W-1:0]       wcnt_reg;
    logic [STAMP_W-1:0]      arr_reg;
    logic [1:0]              open_rank_reg;
    logic [2:0]              open_bank_reg;
    logic [ROW_W-1:0]        open_row_reg;
    logic                    drain_reg;
    logic [TIME_W-1:0]       last_srv_reg [THREAD_COUNT];
    logic [1:0]              pcnt_reg [THREAD_COUNT];
    logic [PRIO_W-1:0]       prio_reg [THREAD_COUNT];
    logic [SCN_W-1:0]        scan_idx_reg;
    logic                    pipe_v_reg;
    logic [SIDX_W-1:0]       pipe_idx_reg;
    logic                    have_reg;
    logic [SIDX_W-1:0]       best_idx_reg;
    logic [STAMP_W-1:0]      best_age_reg;
    logic [PRIO_W-1:0]       best_p_reg;
    logic [THR_W-1:0]        best_thr_reg;
    logic [1:0]              best_rank_reg;
    logic [2:0]              best_bank_reg;
    logic [ROW_W-1:0]        best_row_reg;
    logic [THR_W-1:0]        thr_idx_reg;
    logic                    div_run_reg;
    mads_rsp_t               res_reg;
    logic                    out_valid_reg;
    mads_rsp_t               out_reg;
    mads_rsp_t               out_next;

    mads_rent_t              rent;
    mads_rent_t              rent_wr;
    logic [STAMP_W-1:0]      wstamp;
    logic [RIDX_W-1:0]       rfree;
    logic [WIDX_W-1:0]       wfree;
    logic                    rfull;
    logic                    wfull;
    logic [RIDX_W-1:0]       slot_r;
    logic [WIDX_W-1:0]       slot_w;
    logic                    slot_r_ok;
    logic                    slot_w_ok;
    logic                    drain_new;
    logic [SCN_W-1:0]        scan_end;
    logic                    scan_done;
    logic [RIDX_W-1:0]       pi_r;
    logic [WIDX_W-1:0]       pi_w;
    logic [STAMP_W-1:0]      age_r;
    logic [STAMP_W-1:0]      age_w;
    logic [PRIO_W-1:0]       p_cur;
    logic                    take;
    logic                    rram_we;
    logic                    wram_we;
    logic                    div_start;
    logic                    div_done;
    logic [TIME_W-1:0]       div_q;
    logic [TIME_W-1:0]       wait_cyc;
    logic [PRIO_W-1:0]       prio_new;
    logic                    out_load;
    mads_rsp_t               exec_res;

    function automatic logic [1:0] base_of(input logic [1:0] c);
        logic [1:0] b;
        if (c == 2'd0)
        begin
            b = 2'd3;
        end
        else if (c == 2'd3)
        begin
            b = 2'd1;
        end
        else
        begin
            b = 2'd2;
        end
        return b;
    endfunction

    // queue memories
    assign rent_wr.thread = cmd_reg.thread;
    assign rent_wr.rank   = cmd_reg.rank;
    assign rent_wr.bank   = cmd_reg.bank;
    assign rent_wr.row    = cmd_reg.row;
    assign rent_wr.stamp  = arr_reg;
    assign rram_we = (state_reg == S_EXEC) && (cmd_reg.op == OP_ADD_RD) && !rfull;
    assign wram_we = (state_reg == S_EXEC) && (cmd_reg.op == OP_ADD_WR) && !wfull;

    mads_ram #(.WIDTH($bits(mads_rent_t)), .DEPTH(READ_DEPTH)) u_rram (
        .clk   (clk),
        .we    (rram_we),
        .waddr (rfree),
        .wdata (rent_wr),
        .raddr (scan_idx_reg[RIDX_W-1:0]),
        .rdata (rent)
    );

    mads_ram #(.WIDTH(STAMP_W), .DEPTH(WRITE_DEPTH)) u_wram (
        .clk   (clk),
        .we    (wram_we),
        .waddr (wfree),
        .wdata (arr_reg),
        .raddr (scan_idx_reg[WIDX_W-1:0]),
        .rdata (wstamp)
    );

    // aging divider
    assign div_start = (state_reg == S_DIV) && !div_run_reg;
    assign wait_cyc  = cmd_reg.now - last_srv_reg[thr_idx_reg];

    mads_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (wait_cyc),
        .divisor  (cfg.aging),
        .done     (div_done),
        .quotient (div_q)
    );

    assign prio_new = PRIO_W'(base_of(pcnt_reg[thr_idx_reg]))
                    + ((cfg.aging == '0) ? '0 : PRIO_W'(div_q));

    // lowest free slot of each queue
    always_comb
    begin
        rfree = '0;
        for (int i = READ_DEPTH - 1; i >= 0; i--)
        begin
            if (!rvalid_reg[i])
            begin
                rfree = RIDX_W'(i);
            end
        end
        wfree = '0;
        for (int i = WRITE_DEPTH - 1; i >= 0; i--)
        begin
            if (!wvalid_reg[i])
            begin
                wfree = WIDX_W'(i);
            end
        end
    end

    assign rfull     = &rvalid_reg;
    assign wfull     = &wvalid_reg;
    assign slot_r    = cmd_reg.slot[RIDX_W-1:0];
    assign slot_w    = cmd_reg.slot[WIDX_W-1:0];
    assign slot_r_ok = (32'(cmd_reg.slot) < READ_DEPTH) && rvalid_reg[slot_r];
    assign slot_w_ok = (32'(cmd_reg.slot) < WRITE_DEPTH) && wvalid_reg[slot_w];

    // drain mode for a schedule item
    assign drain_new = (drain_reg && (32'(wcnt_reg) > 32'(cfg.low_wm)))
                     || (32'(wcnt_reg) > 32'(cfg.high_wm)) || (rcnt_reg == '0);

    // scan stage evaluation
    assign scan_end  = (state_reg == S_SCAN_W) ? SCN_W'(WRITE_DEPTH) : SCN_W'(READ_DEPTH);
    assign scan_done = (scan_idx_reg == scan_end) && !pipe_v_reg;
    assign pi_r      = pipe_idx_reg[RIDX_W-1:0];
    assign pi_w      = pipe_idx_reg[WIDX_W-1:0];
    assign age_r     = arr_reg - rent.stamp;
    assign age_w     = arr_reg - wstamp;
    assign p_cur     = prio_reg[rent.thread];

    always_comb
    begin
        take = 1'b0;
        if (pipe_v_reg)
        begin
            case (state_reg)
                S_SCAN_W:
                begin
                    take = wvalid_reg[pi_w] && wready_reg[pi_w]
                        && (!have_reg || (age_w > best_age_reg));
                end
                S_SCAN_HIT:
                begin
                    take = rvalid_reg[pi_r] && rready_reg[pi_r]
                        && (rent.rank == open_rank_reg) && (rent.bank == open_bank_reg)
                        && (rent.row == open_row_reg)
                        && (!have_reg || (age_r > best_age_reg));
                end
                S_SCAN_PRI:
                begin
                    take = rvalid_reg[pi_r] && rready_reg[pi_r]
                        && (!have_reg || (p_cur > best_p_reg)
                            || ((p_cur == best_p_reg) && (age_r > best_age_reg)));
                end
                default:
                begin
                    take = 1'b0;
                end
            endcase
        end
    end

    // result of the single-step operations
    always_comb
    begin
        exec_res = '0;
        case (cmd_reg.op) inside
            OP_ADD_RD:
            begin
                if (rfull)
                begin
                    exec_res.status = ST_FULL;
                end
                else
                begin
                    exec_res.assigned_slot = SLOT_W'(rfree);
                end
            end
            OP_ADD_WR:
            begin
                if (wfull)
                begin
                    exec_res.status = ST_FULL;
                end
                else
                begin
                    exec_res.assigned_slot = SLOT_W'(wfree);
                end
            end
            OP_FLAGS, OP_REMOVE:
            begin
                if (cmd_reg.qsel ? !slot_w_ok : !slot_r_ok)
                begin
                    exec_res.status = ST_BAD;
                end
            end
            OP_SCHED:
            begin
                exec_res.status = ST_OK;
            end
            default:
            begin
                exec_res.status = ST_BAD;
            end
        endcase
    end

    // result with the current drain mode
    always_comb
    begin
        out_next            = res_reg;
        out_next.drain_mode = drain_reg;
    end

    assign cmd_ready = state_reg == S_IDLE;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || rsp.ready);

    // control state and queue bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rvalid_reg    <= '0;
            rready_reg    <= '0;
            rpend_reg     <= '0;
            wvalid_reg    <= '0;
            wready_reg    <= '0;
            rcnt_reg      <= '0;
            wcnt_reg      <= '0;
            arr_reg       <= '0;
            open_rank_reg <= '0;
            open_bank_reg <= '0;
            open_row_reg  <= '0;
            drain_reg     <= 1'b0;
            scan_idx_reg  <= '0;
            pipe_v_reg    <= 1'b0;
            have_reg      <= 1'b0;
            thr_idx_reg   <= '0;
            div_run_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < THREAD_COUNT; t++)
            begin
                last_srv_reg[t] <= '0;
                pcnt_reg[t]     <= '0;
            end
        end
        else
        begin
            // output register handshake
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // shared scan pointer
            if ((state_reg == S_SCAN_W) || (state_reg == S_SCAN_HIT)
                || (state_reg == S_SCAN_PRI))
            begin
                if (scan_idx_reg != scan_end)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                    pipe_v_reg   <= 1'b1;
                end
                else
                begin
                    pipe_v_reg <= 1'b0;
                end
                if (take)
                begin
                    have_reg <= 1'b1;
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_OUT;
                    case (cmd_reg.op)
                        OP_ADD_RD:
                        begin
                            if (!rfull)
                            begin
                                rvalid_reg[rfree] <= 1'b1;
                                rready_reg[rfree] <= cmd_reg.rdy;
                                rpend_reg[rfree]  <= cmd_reg.pend;
                                arr_reg           <= arr_reg + 1'b1;
                                rcnt_reg          <= rcnt_reg + 1'b1;
                            end
                        end
                        OP_ADD_WR:
                        begin
                            if (!wfull)
                            begin
                                wvalid_reg[wfree] <= 1'b1;
                                wready_reg[wfree] <= cmd_reg.rdy;
                                arr_reg           <= arr_reg + 1'b1;
                                wcnt_reg          <= wcnt_reg + 1'b1;
                            end
                        end
                        OP_FLAGS:
                        begin
                            if (cmd_reg.qsel && slot_w_ok)
                            begin
                                wready_reg[slot_w] <= cmd_reg.rdy;
                            end
                            else if (!cmd_reg.qsel && slot_r_ok)
                            begin
                                rready_reg[slot_r] <= cmd_reg.rdy;
                                rpend_reg[slot_r]  <= cmd_reg.pend;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (cmd_reg.qsel && slot_w_ok)
                            begin
                                wvalid_reg[slot_w] <= 1'b0;
                                wcnt_reg           <= wcnt_reg - 1'b1;
                            end
                            else if (!cmd_reg.qsel && slot_r_ok)
                            begin
                                rvalid_reg[slot_r] <= 1'b0;
                                rcnt_reg           <= rcnt_reg - 1'b1;
                            end
                        end
                        OP_SCHED:
                        begin
                            drain_reg    <= drain_new;
                            scan_idx_reg <= '0;
                            pipe_v_reg   <= 1'b0;
                            have_reg     <= 1'b0;
                            for (int t = 0; t < THREAD_COUNT; t++)
                            begin
                                pcnt_reg[t] <= '0;
                            end
                            state_reg <= drain_new ? S_SCAN_W : S_SCAN_HIT;
                        end
                        default:
                        begin
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_SCAN_W:
                begin
                    if (scan_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_SCAN_HIT:
                begin
                    // count pending reads per thread on the same pass
                    if (pipe_v_reg && rvalid_reg[pi_r] && rpend_reg[pi_r]
                        && (pcnt_reg[rent.thread] != 2'd3))
                    begin
                        pcnt_reg[rent.thread] <= pcnt_reg[rent.thread] + 1'b1;
                    end
                    if (scan_done)
                    begin
                        if (have_reg)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            thr_idx_reg <= '0;
                            div_run_reg <= 1'b0;
                            state_reg   <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_start)
                    begin
                        div_run_reg <= 1'b1;
                    end
                    else if (div_done)
                    begin
                        div_run_reg <= 1'b0;
                        if (thr_idx_reg == THR_W'(THREAD_COUNT - 1))
                        begin
                            scan_idx_reg <= '0;
                            pipe_v_reg   <= 1'b0;
                            state_reg    <= S_SCAN_PRI;
                        end
                        else
                        begin
                            thr_idx_reg <= thr_idx_reg + 1'b1;
                        end
                    end
                end
                S_SCAN_PRI:
                begin
                    if (scan_done)
                    begin
                        if (have_reg)
                        begin
                            open_rank_reg              <= best_rank_reg;
                            open_bank_reg              <= best_bank_reg;
                            open_row_reg               <= best_row_reg;
                            last_srv_reg[best_thr_reg] <= cmd_reg.now;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload: command, best candidate, priorities and results
    always_ff @(posedge clk)
    begin
        pipe_idx_reg <= scan_idx_reg[SIDX_W-1:0];
        if ((state_reg == S_IDLE) && cmd_valid)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == S_EXEC)
        begin
            res_reg <= exec_res;
        end
        if (take)
        begin
            best_idx_reg  <= pipe_idx_reg;
            best_age_reg  <= (state_reg == S_SCAN_W) ? age_w : age_r;
            best_p_reg    <= p_cur;
            best_thr_reg  <= rent.thread;
            best_rank_reg <= rent.rank;
            best_bank_reg <= rent.bank;
            best_row_reg  <= rent.row;
        end
        if ((state_reg == S_DIV) && !div_start && div_done)
        begin
            prio_reg[thr_idx_reg] <= prio_new;
        end
        if (((state_reg == S_SCAN_W) || (state_reg == S_SCAN_HIT)
            || (state_reg == S_SCAN_PRI)) && scan_done && have_reg)
        begin
            res_reg.issued       <= 1'b1;
            res_reg.issued_queue <= state_reg == S_SCAN_W;
            res_reg.issued_slot  <= SLOT_W'(best_idx_reg);
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;
endmodule

// ===== hw/rtl/mlp_aware_dram_read_write_scheduler.sv =====
// top level of the mlp aware dram read/write scheduler
//
//  channel  | dir | handshake          | payload
//  req_ch   | in  | valid/ready        | req_type .. now_cycle
//  rsp_ch   | out | valid/ready        | status .. drain_mode
//  cfg      | in  | cfg_we, no wait    | cfg_index, cfg_data
//
// add, set flags, remove and bad items pass the back end states idle, exec and out.
// a schedule item scans a queue one slot per cycle through the queue memory read
// port. in drain it scans writes, else reads for an open row hit; with no hit, the
// shared bit-serial aging divider runs once per thread, then a second read scan.
// reset clears valid bits, counts, open row, drain mode and service times at once.
// a two-entry command queue and the result register let either side stall alone.
`timescale 1ns / 1ps
module mlp_aware_dram_read_write_scheduler (
    input  logic                           clk,
    input  logic                           rst_n,
    mads_req_if.sink                       req_ch,
    mads_rsp_if.source                     rsp_ch,
    input  logic                           cfg_we,
    input  logic [mads_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mads_pkg::CFG_W-1:0]     cfg_data
);
    import mads_pkg::*;

    mads_cfg_t cfg_reg;
    mads_cmd_t cmd;
    logic      cmd_valid;
    logic      cmd_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_wm <= HI_WM_RST;
            cfg_reg.low_wm  <= LO_WM_RST;
            cfg_reg.aging   <= AGING_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HIGH_WM: cfg_reg.high_wm <= cfg_data[WM_W-1:0];
                CFG_LOW_WM:  cfg_reg.low_wm  <= cfg_data[WM_W-1:0];
                CFG_AGING:   cfg_reg.aging   <= cfg_data[APER_W-1:0];
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

    // front end and command queue
    mads_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    // back end
    mads_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cfg       (cfg_reg),
        .rsp       (rsp_ch)
    );

    // an issued result always carries ok status
    a_issue_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ch.valid && rsp_ch.data.issued |-> rsp_ch.data.status == ST_OK)
        else $error("issued result with error status");

    // no issue means no issue slot or queue
    a_no_issue_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ch.valid && !rsp_ch.data.issued
        |-> !rsp_ch.data.issued_queue && (rsp_ch.data.issued_slot == '0))
        else $error("issue fields set without issue");

    // status is a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ch.valid |-> (rsp_ch.data.status == ST_OK) || (rsp_ch.data.status == ST_FULL)
        || (rsp_ch.data.status == ST_BAD))
        else $error("undefined status code");

    // aging period write lands in the register
    a_cfg_aging: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index == CFG_AGING) |=> cfg_reg.aging == $past(cfg_data[APER_W-1:0]))
        else $error("aging period write lost");
endmodule
